// ----- rtl/tsmm_pkg.sv -----
package tsmm_pkg;

	// request kinds
	localparam logic [1:0] FUNC_ORIENT = 2'd0;
	localparam logic [1:0] FUNC_ACCEL  = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_ENABLE        = 3'd0;
	localparam logic [2:0] REG_OFFSET_ROLL   = 3'd1;
	localparam logic [2:0] REG_OFFSET_PITCH  = 3'd2;
	localparam logic [2:0] REG_CHAIN_RIGHT   = 3'd3;
	localparam logic [2:0] REG_LEAN_THRESH   = 3'd4;
	localparam logic [2:0] REG_VAR_LIMIT     = 3'd5;
	localparam logic [2:0] REG_MOTION_THRESH = 3'd6;
	localparam logic [2:0] REG_MOTION_HOLD   = 3'd7;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// 70 degrees times 64
	localparam logic signed [15:0] CRASH_LIMIT = 16'sd4480;

	typedef enum logic [2:0] {
		MSRC_HOLD,
		MSRC_SUM_R,
		MSRC_SUM_P,
		MSRC_AX,
		MSRC_AY,
		MSRC_AZ
	} mul_src_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MAG_LOAD,
		OP_MAG_ADD,
		OP_MAG_CHECK,
		OP_SCALE,
		OP_TAKE_R,
		OP_TAKE_P,
		OP_COMPARE
	} dp_op_t;

	typedef struct packed {
		logic     capture;
		logic     update;
		logic     clr_acc;
		logic     walk_rd;
		mul_src_t mul_src;
		dp_op_t   op;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       enable;
		logic       window_full;
		logic       walk_last;
		logic       pipe_busy;
	} dp_status_t;

endpackage

// ----- rtl/tsmm_datapath.sv -----
module tsmm_datapath #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tsmm_pkg::dp_cmd_t                  cmd,
	output tsmm_pkg::dp_status_t               status,
	input  logic                               cfg_wen,
	input  logic [tsmm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsmm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [1:0]                         func,
	input  logic signed [14:0]                 roll_raw,
	input  logic signed [13:0]                 pitch_raw,
	input  logic signed [15:0]                 accel_x,
	input  logic signed [15:0]                 accel_y,
	input  logic signed [15:0]                 accel_z,
	output logic                               stationary,
	output logic                               crashed,
	output logic                               motion_recent,
	output logic                               leaning_to_tire,
	output logic signed [15:0]                 roll_now,
	output logic signed [15:0]                 pitch_now
);

	localparam int ADDR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int STEP_W  = ADDR_W + 1;
	localparam int SUM_W   = 16 + ADDR_W;
	localparam int SUMSQ_W = 31 + ADDR_W;
	localparam int X_W     = 2 * SUM_W;
	localparam logic [ADDR_W-1:0] SLOT_LAST = ADDR_W'(WINDOW_DEPTH - 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * WINDOW_DEPTH - 1);
	localparam logic [X_W-1:0]    DEPTH_X   = X_W'(WINDOW_DEPTH);
	localparam logic [X_W-1:0]    DEPTH_SQ_X = X_W'(WINDOW_DEPTH * WINDOW_DEPTH);

	// configuration
	logic                enable_q;
	logic signed [14:0]  off_roll_q;
	logic signed [14:0]  off_pitch_q;
	logic                chain_right_q;
	logic [13:0]         lean_thr_q;
	logic [23:0]         var_limit_q;
	logic [31:0]         motion_thr_q;
	logic [15:0]         motion_hold_q;

	// captured request
	logic [1:0]          func_q;
	logic signed [14:0]  roll_raw_q;
	logic signed [13:0]  pitch_raw_q;
	logic signed [15:0]  accel_x_q;
	logic signed [15:0]  accel_y_q;
	logic signed [15:0]  accel_z_q;

	// monitor state
	logic [31:0]         win_mem [WINDOW_DEPTH];
	logic [ADDR_W-1:0]   slot_q;
	logic                full_q;
	logic signed [15:0]  roll_latest_q;
	logic signed [15:0]  pitch_latest_q;
	logic [15:0]         ticks_q;
	logic [31:0]         mag_q;

	// walk and arithmetic
	logic [STEP_W-1:0]   step_q;
	logic [31:0]         rd_s1;
	logic                v_s1, h_s1, v_s2, h_s2, v_s3, h_s3;
	logic signed [SUM_W-1:0] mul_op_s2;
	logic signed [X_W-1:0]   prod_s3;
	logic signed [SUM_W-1:0] op_s3;
	logic signed [SUM_W-1:0] sum_r_q, sum_p_q;
	logic [SUMSQ_W-1:0]      sumsq_r_q, sumsq_p_q;
	logic [X_W-1:0]          var_r_q, var_p_q, lim_q;
	logic                    still_q;

	logic signed [15:0]  roll_corr;
	logic signed [15:0]  pitch_corr;
	logic signed [15:0]  rd_roll, rd_pitch;
	logic signed [15:0]  lean_thr_s;
	logic                orient_wr;

	assign roll_corr  = {roll_raw_q[14], roll_raw_q} - {off_roll_q[14], off_roll_q};
	assign pitch_corr = {{2{pitch_raw_q[13]}}, pitch_raw_q} - {off_pitch_q[14], off_pitch_q};
	assign orient_wr  = cmd.update && enable_q && (func_q == tsmm_pkg::FUNC_ORIENT);
	assign rd_roll    = rd_s1[31:16];
	assign rd_pitch   = rd_s1[15:0];
	assign lean_thr_s = $signed({2'b00, lean_thr_q});

	always_comb begin
		status.func        = func_q;
		status.enable      = enable_q;
		status.window_full = full_q;
		status.walk_last   = (step_q == STEP_LAST);
		status.pipe_busy   = v_s1 | v_s2 | v_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b1;
			off_roll_q    <= '0;
			off_pitch_q   <= '0;
			chain_right_q <= 1'b1;
			lean_thr_q    <= 14'd640;
			var_limit_q   <= 24'd2048;
			motion_thr_q  <= 32'd16384;
			motion_hold_q <= 16'd5000;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				tsmm_pkg::REG_ENABLE:        enable_q      <= cfg_data[0];
				tsmm_pkg::REG_OFFSET_ROLL:   off_roll_q    <= $signed(cfg_data[14:0]);
				tsmm_pkg::REG_OFFSET_PITCH:  off_pitch_q   <= $signed(cfg_data[14:0]);
				tsmm_pkg::REG_CHAIN_RIGHT:   chain_right_q <= cfg_data[0];
				tsmm_pkg::REG_LEAN_THRESH:   lean_thr_q    <= cfg_data[13:0];
				tsmm_pkg::REG_VAR_LIMIT:     var_limit_q   <= cfg_data[23:0];
				tsmm_pkg::REG_MOTION_THRESH: motion_thr_q  <= cfg_data[31:0];
				tsmm_pkg::REG_MOTION_HOLD:   motion_hold_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q      <= func;
			roll_raw_q  <= roll_raw;
			pitch_raw_q <= pitch_raw;
			accel_x_q   <= accel_x;
			accel_y_q   <= accel_y;
			accel_z_q   <= accel_z;
		end
	end

	// window store, one packed roll/pitch entry per slot
	always_ff @(posedge clk) begin
		if (orient_wr)
			win_mem[slot_q] <= {roll_corr, pitch_corr};
		if (cmd.walk_rd)
			rd_s1 <= win_mem[step_q[STEP_W-1:1]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q         <= '0;
			full_q         <= 1'b0;
			roll_latest_q  <= '0;
			pitch_latest_q <= '0;
			ticks_q        <= '0;
		end else begin
			if (orient_wr) begin
				roll_latest_q  <= roll_corr;
				pitch_latest_q <= pitch_corr;
				if (slot_q == SLOT_LAST) begin
					slot_q <= '0;
					full_q <= 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (cmd.update && (func_q == tsmm_pkg::FUNC_TICK) && (ticks_q != 16'hFFFF))
				ticks_q <= ticks_q + 1'b1;
			else if ((cmd.op == tsmm_pkg::OP_MAG_CHECK) && (mag_q > motion_thr_q))
				ticks_q <= '0;
		end
	end

	// walk pipeline: read, select operand, square, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			if (cmd.clr_acc)
				step_q <= '0;
			else if (cmd.walk_rd)
				step_q <= step_q + 1'b1;
			v_s1 <= cmd.walk_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		h_s1 <= step_q[0];
		h_s2 <= h_s1;
		h_s3 <= h_s2;
		if (v_s1) begin
			mul_op_s2 <= h_s1 ? SUM_W'(rd_pitch) : SUM_W'(rd_roll);
		end else begin
			case (cmd.mul_src)
				tsmm_pkg::MSRC_SUM_R: mul_op_s2 <= sum_r_q;
				tsmm_pkg::MSRC_SUM_P: mul_op_s2 <= sum_p_q;
				tsmm_pkg::MSRC_AX:    mul_op_s2 <= SUM_W'(accel_x_q);
				tsmm_pkg::MSRC_AY:    mul_op_s2 <= SUM_W'(accel_y_q);
				tsmm_pkg::MSRC_AZ:    mul_op_s2 <= SUM_W'(accel_z_q);
				default: ;
			endcase
		end
		prod_s3 <= mul_op_s2 * mul_op_s2;
		op_s3   <= mul_op_s2;

		if (cmd.clr_acc) begin
			sum_r_q   <= '0;
			sum_p_q   <= '0;
			sumsq_r_q <= '0;
			sumsq_p_q <= '0;
		end else if (v_s3) begin
			if (h_s3) begin
				sum_p_q   <= sum_p_q + op_s3;
				sumsq_p_q <= sumsq_p_q + prod_s3[SUMSQ_W-1:0];
			end else begin
				sum_r_q   <= sum_r_q + op_s3;
				sumsq_r_q <= sumsq_r_q + prod_s3[SUMSQ_W-1:0];
			end
		end

		// variance < limit  <=>  N*sumsq - sum^2 < limit * N^2
		case (cmd.op)
			tsmm_pkg::OP_MAG_LOAD: mag_q <= prod_s3[31:0];
			tsmm_pkg::OP_MAG_ADD:  mag_q <= mag_q + prod_s3[31:0];
			tsmm_pkg::OP_SCALE: begin
				var_r_q <= X_W'(sumsq_r_q) * DEPTH_X;
				var_p_q <= X_W'(sumsq_p_q) * DEPTH_X;
				lim_q   <= X_W'(var_limit_q) * DEPTH_SQ_X;
			end
			tsmm_pkg::OP_TAKE_R:   var_r_q <= var_r_q - $unsigned(prod_s3);
			tsmm_pkg::OP_TAKE_P:   var_p_q <= var_p_q - $unsigned(prod_s3);
			tsmm_pkg::OP_COMPARE:  still_q <= (var_r_q < lim_q) && (var_p_q < lim_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			stationary      <= enable_q && full_q && still_q;
			crashed         <= enable_q &&
				((roll_latest_q > tsmm_pkg::CRASH_LIMIT) ||
				 (roll_latest_q < -tsmm_pkg::CRASH_LIMIT) ||
				 (pitch_latest_q > tsmm_pkg::CRASH_LIMIT) ||
				 (pitch_latest_q < -tsmm_pkg::CRASH_LIMIT));
			motion_recent   <= !enable_q || (ticks_q < motion_hold_q);
			leaning_to_tire <= enable_q && (chain_right_q ?
				(roll_latest_q < -lean_thr_s) : (roll_latest_q > lean_thr_s));
			roll_now        <= roll_latest_q;
			pitch_now       <= pitch_latest_q;
		end
	end

endmodule

// ----- rtl/tsmm_ctrl.sv -----
module tsmm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  tsmm_pkg::dp_status_t status,
	output tsmm_pkg::dp_cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_ACC_X,
		ST_ACC_Y,
		ST_ACC_Z,
		ST_ACC_S1,
		ST_ACC_S2,
		ST_ACC_CHK,
		ST_DECIDE,
		ST_WALK,
		ST_DRAIN,
		ST_FIN0,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3,
		ST_FIN4,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd          = '0;
		cmd.mul_src  = tsmm_pkg::MSRC_HOLD;
		cmd.op       = tsmm_pkg::OP_NONE;
		unique case (state_q)
			ST_IDLE:    cmd.capture = in_valid;
			ST_UPDATE:  cmd.update = 1'b1;
			ST_ACC_X:   cmd.mul_src = tsmm_pkg::MSRC_AX;
			ST_ACC_Y:   cmd.mul_src = tsmm_pkg::MSRC_AY;
			ST_ACC_Z: begin
				cmd.mul_src = tsmm_pkg::MSRC_AZ;
				cmd.op      = tsmm_pkg::OP_MAG_LOAD;
			end
			ST_ACC_S1:  cmd.op = tsmm_pkg::OP_MAG_ADD;
			ST_ACC_S2:  cmd.op = tsmm_pkg::OP_MAG_ADD;
			ST_ACC_CHK: cmd.op = tsmm_pkg::OP_MAG_CHECK;
			ST_DECIDE:  cmd.clr_acc = 1'b1;
			ST_WALK:    cmd.walk_rd = 1'b1;
			ST_DRAIN:   ;
			ST_FIN0: begin
				cmd.mul_src = tsmm_pkg::MSRC_SUM_R;
				cmd.op      = tsmm_pkg::OP_SCALE;
			end
			ST_FIN1:    cmd.mul_src = tsmm_pkg::MSRC_SUM_P;
			ST_FIN2:    cmd.op = tsmm_pkg::OP_TAKE_R;
			ST_FIN3:    cmd.op = tsmm_pkg::OP_TAKE_P;
			ST_FIN4:    cmd.op = tsmm_pkg::OP_COMPARE;
			ST_DONE:    cmd.load_out = out_free;
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// result register frees while the next request is worked on
			out_valid_q <= cmd.load_out || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE:    if (in_valid) state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (status.enable && (status.func == tsmm_pkg::FUNC_ACCEL))
						state_q <= ST_ACC_X;
					else
						state_q <= ST_DECIDE;
				end
				ST_ACC_X:   state_q <= ST_ACC_Y;
				ST_ACC_Y:   state_q <= ST_ACC_Z;
				ST_ACC_Z:   state_q <= ST_ACC_S1;
				ST_ACC_S1:  state_q <= ST_ACC_S2;
				ST_ACC_S2:  state_q <= ST_ACC_CHK;
				ST_ACC_CHK: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if (status.enable && status.window_full)
						state_q <= ST_WALK;
					else
						state_q <= ST_DONE;
				end
				ST_WALK:    if (status.walk_last) state_q <= ST_DRAIN;
				ST_DRAIN:   if (!status.pipe_busy) state_q <= ST_FIN0;
				ST_FIN0:    state_q <= ST_FIN1;
				ST_FIN1:    state_q <= ST_FIN2;
				ST_FIN2:    state_q <= ST_FIN3;
				ST_FIN3:    state_q <= ST_FIN4;
				ST_FIN4:    state_q <= ST_DONE;
				ST_DONE:    if (out_free) state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/tilt_stillness_motion_monitor.sv -----
// sequence: update; for an enabled acceleration request, square and sum the axes against
// the motion threshold; when enabled with the window full, walk, drain, scale and compare.
// throughput: no new request is taken until the last result is loaded; the single
// squaring multiplier walks both windows, one entry half per cycle, and a finished
// result may wait while the next is taken.
// reset: arst_n clears control, timer, window pointer and loads register defaults;
// window entries are not cleared and are read only once the window has filled.
module tilt_stillness_motion_monitor #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         func,
	input  logic signed [14:0]                 roll_raw,
	input  logic signed [13:0]                 pitch_raw,
	input  logic signed [15:0]                 accel_x,
	input  logic signed [15:0]                 accel_y,
	input  logic signed [15:0]                 accel_z,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               stationary,
	output logic                               crashed,
	output logic                               motion_recent,
	output logic                               leaning_to_tire,
	output logic signed [15:0]                 roll_now,
	output logic signed [15:0]                 pitch_now,
	input  logic                               cfg_wen,
	input  logic [tsmm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsmm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	tsmm_pkg::dp_cmd_t    cmd;
	tsmm_pkg::dp_status_t status;

	tsmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	tsmm_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.func            (func),
		.roll_raw        (roll_raw),
		.pitch_raw       (pitch_raw),
		.accel_x         (accel_x),
		.accel_y         (accel_y),
		.accel_z         (accel_z),
		.stationary      (stationary),
		.crashed         (crashed),
		.motion_recent   (motion_recent),
		.leaning_to_tire (leaning_to_tire),
		.roll_now        (roll_now),
		.pitch_now       (pitch_now)
	);

	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid && out_stall))
		else $error("result overwritten while stalled");

	// window is only walked once every entry has been written
	a_walk_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_rd |-> (status.window_full && status.enable))
		else $error("window walked before full");

	// accumulators settled before the sum squares are taken
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == tsmm_pkg::OP_SCALE) |-> !status.pipe_busy)
		else $error("finish started with walk in flight");

	// block is busy in the cycle after it takes a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted back to back");

endmodule

// ----- tb/testbench.sv -----
module testbench;

	localparam int WINDOW = 16;
	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int DRAIN_CYCLES = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS = 100;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_ITEMS = 250;
	localparam int RANDOM_PHASES = 8;
	localparam int SHORT_HOLD = 100;

	typedef struct {
		logic [1:0]         kind;
		logic signed [14:0] roll;
		logic signed [13:0] pitch;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} sensor_req_t;

	typedef struct {
		logic               stationary;
		logic               crashed;
		logic               motion_recent;
		logic               leaning;
		logic signed [15:0] roll_now;
		logic signed [15:0] pitch_now;
	} status_t;

	typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_RUNS} rx_mode_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = '0;
	logic signed [14:0] roll_raw = '0;
	logic signed [13:0] pitch_raw = '0;
	logic signed [15:0] accel_x = '0;
	logic signed [15:0] accel_y = '0;
	logic signed [15:0] accel_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic stationary;
	logic crashed;
	logic motion_recent;
	logic leaning_to_tire;
	logic signed [15:0] roll_now;
	logic signed [15:0] pitch_now;
	logic cfg_wen = 1'b0;
	logic [tsmm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tsmm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	tilt_stillness_motion_monitor #(.WINDOW_DEPTH(WINDOW)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.roll_raw(roll_raw),
		.pitch_raw(pitch_raw),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stationary(stationary),
		.crashed(crashed),
		.motion_recent(motion_recent),
		.leaning_to_tire(leaning_to_tire),
		.roll_now(roll_now),
		.pitch_now(pitch_now),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor copy of the registers
	logic               cfg_enable = 1'b1;
	logic signed [14:0] cfg_off_roll = '0;
	logic signed [14:0] cfg_off_pitch = '0;
	logic               cfg_chain_right = 1'b1;
	logic [13:0]        cfg_lean = 14'd640;
	logic [23:0]        cfg_var_limit = 24'd2048;
	logic [31:0]        cfg_motion_thr = 32'd16384;
	logic [15:0]        cfg_hold = 16'd5000;

	// predictor copy of the state
	int roll_hist [WINDOW];
	int pitch_hist [WINDOW];
	int slot = 0;
	bit window_full = 1'b0;
	int roll_last = 0;
	int pitch_last = 0;
	int ticks_idle = 0;

	sensor_req_t pending_reqs[$];
	status_t expected_status[$];
	int n_queued = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_errors = 0;
	int hold_off_asked = 0;
	int hold_off_done = 0;
	bit quiet = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint window_variance(input int h [WINDOW]);
		longint total = 0;
		longint total_sq = 0;
		foreach (h[i]) begin
			total += longint'(h[i]);
			total_sq += longint'(h[i]) * h[i];
		end
		return (WINDOW * total_sq - total * total) / (WINDOW * WINDOW);
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] value);
		case (idx)
			tsmm_pkg::REG_ENABLE: cfg_enable = value[0];
			tsmm_pkg::REG_OFFSET_ROLL: cfg_off_roll = value[14:0];
			tsmm_pkg::REG_OFFSET_PITCH: cfg_off_pitch = value[14:0];
			tsmm_pkg::REG_CHAIN_RIGHT: cfg_chain_right = value[0];
			tsmm_pkg::REG_LEAN_THRESH: cfg_lean = value[13:0];
			tsmm_pkg::REG_VAR_LIMIT: cfg_var_limit = value[23:0];
			tsmm_pkg::REG_MOTION_THRESH: cfg_motion_thr = value;
			tsmm_pkg::REG_MOTION_HOLD: cfg_hold = value[15:0];
			default: ;
		endcase
	endfunction

	function automatic void predict_status(input sensor_req_t r);
		status_t s;
		longint mag;
		int abs_r;
		int abs_p;
		if (r.kind == tsmm_pkg::FUNC_TICK) begin
			if (ticks_idle < 65535)
				ticks_idle++;
		end else if (cfg_enable && r.kind == tsmm_pkg::FUNC_ORIENT) begin
			roll_last = int'(r.roll) - int'(cfg_off_roll);
			pitch_last = int'(r.pitch) - int'(cfg_off_pitch);
			roll_hist[slot] = roll_last;
			pitch_hist[slot] = pitch_last;
			slot = (slot + 1) % WINDOW;
			if (slot == 0)
				window_full = 1'b1;
		end else if (cfg_enable && r.kind == tsmm_pkg::FUNC_ACCEL) begin
			mag = longint'(r.ax) * r.ax + longint'(r.ay) * r.ay + longint'(r.az) * r.az;
			if (mag > longint'(cfg_motion_thr))
				ticks_idle = 0;
		end
		s.stationary = 1'b0;
		s.crashed = 1'b0;
		s.motion_recent = 1'b1;
		s.leaning = 1'b0;
		s.roll_now = roll_last[15:0];
		s.pitch_now = pitch_last[15:0];
		if (cfg_enable) begin
			abs_r = (roll_last < 0) ? -roll_last : roll_last;
			abs_p = (pitch_last < 0) ? -pitch_last : pitch_last;
			if (window_full)
				s.stationary = window_variance(roll_hist) < longint'(cfg_var_limit) &&
					window_variance(pitch_hist) < longint'(cfg_var_limit);
			s.crashed = abs_r > int'(tsmm_pkg::CRASH_LIMIT) ||
				abs_p > int'(tsmm_pkg::CRASH_LIMIT);
			s.motion_recent = ticks_idle < int'(cfg_hold);
			if (cfg_chain_right)
				s.leaning = roll_last < -int'(cfg_lean);
			else
				s.leaning = roll_last > int'(cfg_lean);
		end
		expected_status.push_back(s);
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			if (n_errors < MAX_REPORTS)
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			n_errors++;
		end
	endtask

	// unused fields carry random values
	function automatic sensor_req_t kind_req(input logic [1:0] k);
		sensor_req_t q;
		q.kind = k;
		q.roll = 15'(int'($urandom_range(0, 23040)) - 11520);
		q.pitch = 14'(int'($urandom_range(0, 11520)) - 5760);
		q.ax = 16'($urandom);
		q.ay = 16'($urandom);
		q.az = 16'($urandom);
		return q;
	endfunction

	function automatic sensor_req_t orient_req(input int r, input int p);
		sensor_req_t q;
		q = kind_req(tsmm_pkg::FUNC_ORIENT);
		q.roll = 15'(r);
		q.pitch = 14'(p);
		return q;
	endfunction

	function automatic sensor_req_t accel_req(input int x, input int y, input int z);
		sensor_req_t q;
		q = kind_req(tsmm_pkg::FUNC_ACCEL);
		q.ax = 16'(x);
		q.ay = 16'(y);
		q.az = 16'(z);
		return q;
	endfunction

	function automatic int unsigned pick(input int unsigned lo, input int unsigned hi,
			input int unsigned typ_lo, input int unsigned typ_hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			default: return $urandom_range(typ_hi, typ_lo);
		endcase
	endfunction

	task automatic send_req(input sensor_req_t q);
		pending_reqs.push_back(q);
		n_queued++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		apply_reg(idx, value);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || expected_status.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// request driver
	sensor_req_t cur_req;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_status(cur_req);
				n_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 && !quiet) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					cur_req = pending_reqs.pop_front();
					func <= cur_req.kind;
					roll_raw <= cur_req.roll;
					pitch_raw <= cur_req.pitch;
					accel_x <= cur_req.ax;
					accel_y <= cur_req.ay;
					accel_z <= cur_req.az;
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// status monitor and receiver stalls
	rx_mode_t rx_mode = RX_OPEN;
	int mode_left = 0;
	int stall_hold = 0;

	always @(posedge clk) begin
		status_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (expected_status.size() == 0) begin
					if (n_errors < MAX_REPORTS)
						$display("%0t: status with no request pending: expected none, actual roll %0d pitch %0d",
							$time, roll_now, pitch_now);
					n_errors++;
				end else begin
					want = expected_status.pop_front();
					check_field("stationary", want.stationary, stationary);
					check_field("crashed", want.crashed, crashed);
					check_field("motion_recent", want.motion_recent, motion_recent);
					check_field("leaning_to_tire", want.leaning, leaning_to_tire);
					check_field("roll_now", want.roll_now, roll_now);
					check_field("pitch_now", want.pitch_now, pitch_now);
				end
			end
			if (hold_off_done != hold_off_asked) begin
				hold_off_done++;
				stall_hold = HOLD_OFF_CYCLES;
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(50, 300);
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			end else begin
				mode_left--;
			end
			if (quiet) begin
				out_stall <= 1'b0;
			end else if (stall_hold > 0) begin
				stall_hold--;
				out_stall <= 1'b1;
			end else begin
				case (rx_mode)
					RX_OPEN: out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
				endcase
			end
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("testbench failed");
				$finish;
			end else begin
				idle_cycles++;
			end
		end
	end

	initial begin
		int base_r;
		int base_p;
		int amp;
		int len;
		int n_phase;
		int sel;
		int off;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: spare kind, threshold edge, accel and angle extremes
		send_req(kind_req(FUNC_SPARE));
		send_req(kind_req(tsmm_pkg::FUNC_TICK));
		send_req(accel_req(128, 0, 0));
		send_req(accel_req(-32768, -32768, -32768));
		send_req(accel_req(32767, 32767, 32767));
		send_req(orient_req(11520, 5760));
		send_req(orient_req(-11520, -5760));
		send_req(orient_req(-641, 0));
		send_req(orient_req(-640, 0));
		send_req(orient_req(4480, -4481));
		send_req(orient_req(4481, 4480));
		wait_drained();

		// run the motion timer past a short hold, then restart it
		write_reg(tsmm_pkg::REG_MOTION_HOLD, 32'(SHORT_HOLD));
		quiet = 1'b1;
		repeat (SHORT_HOLD + 10) send_req(kind_req(tsmm_pkg::FUNC_TICK));
		wait_drained();
		quiet = 1'b0;
		send_req(accel_req(0, 0, 129));
		send_req(kind_req(tsmm_pkg::FUNC_TICK));
		wait_drained();

		// disabled: only motion is reported, ticks still count
		write_reg(tsmm_pkg::REG_ENABLE, 32'd0);
		write_reg(tsmm_pkg::REG_MOTION_HOLD, 32'd0);
		send_req(orient_req(100, -100));
		send_req(accel_req(-32768, 0, 0));
		send_req(kind_req(tsmm_pkg::FUNC_TICK));
		send_req(kind_req(FUNC_SPARE));
		wait_drained();

		// offset extremes, chain on the left, zero hold
		write_reg(tsmm_pkg::REG_ENABLE, 32'd1);
		write_reg(tsmm_pkg::REG_OFFSET_ROLL, 32'(11520));
		write_reg(tsmm_pkg::REG_OFFSET_PITCH, 32'(-11520));
		write_reg(tsmm_pkg::REG_CHAIN_RIGHT, 32'd0);
		write_reg(tsmm_pkg::REG_LEAN_THRESH, 32'd0);
		send_req(kind_req(tsmm_pkg::FUNC_TICK));
		send_req(orient_req(-11520, 5760));
		send_req(orient_req(11520, -5760));
		wait_drained();

		write_reg(tsmm_pkg::REG_OFFSET_ROLL, 32'(-11520));
		write_reg(tsmm_pkg::REG_OFFSET_PITCH, 32'(11520));
		write_reg(tsmm_pkg::REG_LEAN_THRESH, 32'd11520);
		send_req(orient_req(11520, -5760));
		send_req(orient_req(0, 0));
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_reg(tsmm_pkg::REG_ENABLE, (ph == 3) ? 32'd0 : 32'd1);
			off = (ph == 1) ? 11520 : int'(pick(0, 23040, 10880, 12160)) - 11520;
			write_reg(tsmm_pkg::REG_OFFSET_ROLL, 32'(off));
			off = (ph == 1) ? -11520 : int'(pick(0, 23040, 10880, 12160)) - 11520;
			write_reg(tsmm_pkg::REG_OFFSET_PITCH, 32'(off));
			write_reg(tsmm_pkg::REG_CHAIN_RIGHT, $urandom_range(0, 1));
			write_reg(tsmm_pkg::REG_LEAN_THRESH, pick(0, 11520, 0, 2000));
			write_reg(tsmm_pkg::REG_VAR_LIMIT, (ph == 0) ? 32'hFFFFFF : (ph == 1) ? 32'd0 :
				pick(0, 24'hFFFFFF, 200, 8000));
			write_reg(tsmm_pkg::REG_MOTION_THRESH, (ph == 0) ? 32'hFFFFFFFF :
				(ph == 1) ? 32'd0 : pick(0, 32'hFFFFFFFF, 2000, 60000));
			write_reg(tsmm_pkg::REG_MOTION_HOLD, (ph == 2) ? 32'd65535 : (ph == 5) ? 32'd0 :
				pick(1, 65535, 1, 60));
			if (ph == 2 || ph == 6)
				hold_off_asked++;
			n_phase = 0;
			while (n_phase < PHASE_ITEMS) begin
				sel = $urandom_range(0, 9);
				if (sel < 7) begin
					// steady stretch: angles scatter around a base so the window can settle
					amp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
					base_r = int'($urandom_range(0, 23040 - 2 * amp)) - (11520 - amp);
					base_p = int'($urandom_range(0, 11520 - 2 * amp)) - (5760 - amp);
					len = $urandom_range(8, 40);
					for (int k = 0; k < len; k++) begin
						sel = $urandom_range(0, 7);
						if (sel < 4)
							send_req(orient_req(base_r + int'($urandom_range(0, 2 * amp)) - amp,
								base_p + int'($urandom_range(0, 2 * amp)) - amp));
						else if (sel < 6)
							send_req(kind_req(tsmm_pkg::FUNC_TICK));
						else if ($urandom_range(0, 7) == 0)
							send_req(accel_req(0, 0, 0));
						else
							send_req(accel_req(int'($urandom_range(0, 400)) - 200,
								int'($urandom_range(0, 400)) - 200,
								int'($urandom_range(0, 400)) - 200));
					end
					n_phase += len;
				end else begin
					len = $urandom_range(1, 10);
					repeat (len) send_req(kind_req(2'($urandom_range(0, 3))));
					n_phase += len;
				end
			end
			wait_drained();
		end

		if (n_errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/tsmm_pkg.sv
rtl/tsmm_datapath.sv
rtl/tsmm_ctrl.sv
rtl/tilt_stillness_motion_monitor.sv
tb/testbench.sv
